@@ rtl/assert_macros.svh @@
// Assertion macros for the blitter RTL (included by csb_core).
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising edge, off during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/csb_pkg.sv @@
// Package for the clipped sprite blitter: screen constants, shared types and codes.
// No dependencies.
package csb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int LINE_STRIDE   = 320;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_RIGHT  = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_W_HI   = 5'b00001,
        PH_H_LO   = 5'b00010,
        PH_H_HI   = 5'b00100,
        PH_IDLE   = 5'b01000,
        PH_PIXELS = 5'b10000
    } phase_t;

    typedef struct packed {
        logic signed [9:0] left;
        logic signed [8:0] top;
        logic signed [9:0] right;
        logic signed [8:0] bottom;
    } clip_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_offset;
        logic [7:0]  pixel_value;
        logic        sprite_done;
    } res_t;

endpackage

@@ rtl/csb_ifs.sv @@
// Valid/ready channel interfaces for the sprite byte input and the pixel write output.
// No dependencies.
interface sprite_in_if;
    logic               valid;
    logic               ready;
    logic               first;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         sprite_byte;

    modport source (output valid, output first, output pos_x, output pos_y,
                    output sprite_byte, input ready);
    modport sink   (input valid, input first, input pos_x, input pos_y,
                    input sprite_byte, output ready);
endinterface

interface blit_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_offset;
    logic [7:0]  pixel_value;
    logic        sprite_done;

    modport source (output valid, output write_enable, output write_offset,
                    output pixel_value, output sprite_done, input ready);
    modport sink   (input valid, input write_enable, input write_offset,
                    input pixel_value, input sprite_done, output ready);
endinterface

@@ rtl/csb_regs.sv @@
// APB register block holding the four clip window edges, saturated on write.
// Depends on csb_pkg.
module csb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output csb_pkg::clip_t                 clip
);
    import csb_pkg::*;

    clip_t             clip_reg;
    clip_t             clip_next;
    logic              wr_en;
    reg_idx_t          idx;
    logic signed [9:0] wide_val;
    logic signed [8:0] narrow_val;
    logic signed [9:0] wide_sat;
    logic signed [8:0] narrow_sat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Saturate to one outside the screen on each side
    always_comb
    begin
        wide_val   = $signed(pwdata[9:0]);
        narrow_val = $signed(pwdata[8:0]);
        if (wide_val < -10'sd1)
            wide_sat = -10'sd1;
        else if (wide_val > $signed(10'(SCREEN_WIDTH)))
            wide_sat = $signed(10'(SCREEN_WIDTH));
        else
            wide_sat = wide_val;
        if (narrow_val < -9'sd1)
            narrow_sat = -9'sd1;
        else if (narrow_val > $signed(9'(SCREEN_HEIGHT)))
            narrow_sat = $signed(9'(SCREEN_HEIGHT));
        else
            narrow_sat = narrow_val;
    end

    always_comb
    begin
        clip_next = clip_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CLIP_LEFT:   clip_next.left   = wide_sat;
                REG_CLIP_TOP:    clip_next.top    = narrow_sat;
                REG_CLIP_RIGHT:  clip_next.right  = wide_sat;
                REG_CLIP_BOTTOM: clip_next.bottom = narrow_sat;
                default:         clip_next = clip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= -10'sd1;
            clip_reg.top    <= -9'sd1;
            clip_reg.right  <= $signed(10'(SCREEN_WIDTH));
            clip_reg.bottom <= $signed(9'(SCREEN_HEIGHT));
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_CLIP_LEFT:   prdata = APB_DATA_W'(clip_reg.left);
            REG_CLIP_TOP:    prdata = APB_DATA_W'(clip_reg.top);
            REG_CLIP_RIGHT:  prdata = APB_DATA_W'(clip_reg.right);
            REG_CLIP_BOTTOM: prdata = APB_DATA_W'(clip_reg.bottom);
            default:         prdata = '0;
        endcase
    end

    assign clip = clip_reg;

endmodule

@@ rtl/csb_core.sv @@
// Sprite parser: header decode, reject decision, column/row/offset counters and
// the per-pixel clip test. Depends on csb_pkg, csb_ifs and assert_macros.svh.
`include "assert_macros.svh"

module csb_core (
    input  logic           clk,
    input  logic           rst_n,
    sprite_in_if.sink      in_ch,
    input  logic           stage_ready,
    input  csb_pkg::clip_t clip,
    output logic           res_load,
    output csb_pkg::res_t  res_next
);
    import csb_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        rejected_reg, rejected_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [15:0] origin_y_reg, origin_y_next;
    logic [15:0] offset_reg, offset_next;

    logic               accept;
    logic [15:0]        height_full;
    logic signed [18:0] ox19, oy19, oxw, oyh;
    logic               reject_now;
    logic signed [17:0] px, py;
    logic               visible;
    logic [16:0]        col_inc, row_inc;
    logic               col_wrap, row_wrap;

    assign in_ch.ready = stage_ready;
    assign accept      = in_ch.valid && stage_ready;
    assign res_load    = accept;

    // Rejection test, evaluated on the last header byte
    always_comb
    begin
        height_full = {in_ch.sprite_byte, height_reg[7:0]};
        ox19 = 19'($signed(origin_x_reg));
        oy19 = 19'($signed(origin_y_reg));
        oxw  = ox19 + $signed({3'b000, width_reg});
        oyh  = oy19 + $signed({3'b000, height_full});
        reject_now = (clip.left >= clip.right) || (clip.top >= clip.bottom)
                  || (oxw <= 19'sd0) || (ox19 > $signed(19'(SCREEN_WIDTH - 1)))
                  || (oyh <= 19'sd0) || (oy19 > $signed(19'(SCREEN_HEIGHT - 1)))
                  || (oxw < 19'(clip.left)) || (ox19 > 19'(clip.right))
                  || (oyh < 19'(clip.top)) || (oy19 > 19'(clip.bottom));
    end

    // Pixel clip test against the live window
    always_comb
    begin
        px = $signed(18'($signed(origin_x_reg))) + $signed({2'b00, col_reg});
        py = $signed(18'($signed(origin_y_reg))) + $signed({2'b00, row_reg});
        visible = !rejected_reg
               && (px > 18'(clip.left)) && (px < 18'(clip.right))
               && (py > 18'(clip.top))  && (py < 18'(clip.bottom));
        col_inc  = {1'b0, col_reg} + 17'd1;
        row_inc  = {1'b0, row_reg} + 17'd1;
        col_wrap = col_inc >= {1'b0, width_reg};
        row_wrap = row_inc >= {1'b0, height_reg};
    end

    always_comb
    begin
        phase_next    = phase_reg;
        rejected_next = rejected_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        offset_next   = offset_reg;
        res_next      = '0;
        if (in_ch.first)
        begin
            origin_x_next = in_ch.pos_x;
            origin_y_next = in_ch.pos_y;
            rejected_next = 1'b1;
            width_next    = {8'h00, in_ch.sprite_byte};
            phase_next    = PH_W_HI;
        end
        else
        begin
            case (phase_reg)
                PH_W_HI:
                begin
                    width_next = {in_ch.sprite_byte, width_reg[7:0]};
                    phase_next = PH_H_LO;
                end
                PH_H_LO:
                begin
                    height_next = {8'h00, in_ch.sprite_byte};
                    phase_next  = PH_H_HI;
                end
                PH_H_HI:
                begin
                    height_next   = height_full;
                    rejected_next = reject_now;
                    col_next      = '0;
                    row_next      = '0;
                    offset_next   = origin_y_reg * 16'(LINE_STRIDE) + origin_x_reg;
                    if (width_reg == 16'd0 || height_full == 16'd0)
                    begin
                        res_next.sprite_done = 1'b1;
                        phase_next           = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    if (visible)
                    begin
                        res_next.write_enable = 1'b1;
                        res_next.write_offset = offset_reg;
                        res_next.pixel_value  = in_ch.sprite_byte;
                    end
                    if (col_wrap)
                    begin
                        // Step to the start of the next row
                        col_next    = '0;
                        row_next    = row_inc[15:0];
                        offset_next = offset_reg + 16'd1 + 16'(LINE_STRIDE) - width_reg;
                        if (row_wrap)
                        begin
                            res_next.sprite_done = 1'b1;
                            phase_next           = PH_IDLE;
                        end
                    end
                    else
                    begin
                        col_next    = col_inc[15:0];
                        offset_next = offset_reg + 16'd1;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            rejected_reg <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            rejected_reg <= rejected_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            offset_reg   <= offset_next;
        end
    end

    `ASSERT_IMPL(a_we_only_in_pixels, accept && res_next.write_enable,
                 phase_reg == PH_PIXELS && !in_ch.first)
    `ASSERT_IMPL(a_rejected_no_write, phase_reg == PH_PIXELS && rejected_reg,
                 !res_next.write_enable)
    `ASSERT_NEXT(a_done_goes_idle, accept && res_next.sprite_done, phase_reg == PH_IDLE)
    `ASSERT_IMPL(a_col_in_range, phase_reg == PH_PIXELS, col_reg < width_reg)

endmodule

@@ rtl/csb_out_reg.sv @@
// Result register: holds one result item until the sink takes it.
// Depends on csb_pkg and csb_ifs.
module csb_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_load,
    input  csb_pkg::res_t res_next,
    output logic          stage_ready,
    blit_out_if.source    out_ch
);
    import csb_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // Accept a new item whenever the register is empty or the held one leaves this cycle
    assign stage_ready = !valid_reg || out_ch.ready;

    always_comb
    begin
        if (res_load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.write_enable = res_reg.write_enable;
    assign out_ch.write_offset = res_reg.write_offset;
    assign out_ch.pixel_value  = res_reg.pixel_value;
    assign out_ch.sprite_done  = res_reg.sprite_done;

endmodule

@@ rtl/clipped_sprite_blit.sv @@
// Clipped sprite blitter: one input byte a cycle in, one pixel write result per byte out.
// Each accepted byte's result is registered in the output register; a new
// byte is taken in every cycle in which the output register is empty or being drained,
// so with the sink ready the rate is one item per cycle, set by the single result register.
// Header bytes and clipped pixels give write_enable low with zero offset and value.
// Clip registers sit at byte addresses 0, 4, 8, 12 (left, top, right, bottom) and
// saturate to one step outside the screen. Depends on csb_pkg, csb_ifs and submodules.
module clipped_sprite_blit (
    input  logic                           clk,
    input  logic                           rst_n,
    sprite_in_if.sink                      sprite_in,
    blit_out_if.source                     blit_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import csb_pkg::*;

    clip_t clip;
    res_t  res_next;
    logic  res_load;
    logic  stage_ready;

    csb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .clip    (clip)
    );

    csb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (sprite_in),
        .stage_ready (stage_ready),
        .clip        (clip),
        .res_load    (res_load),
        .res_next    (res_next)
    );

    csb_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_load    (res_load),
        .res_next    (res_next),
        .stage_ready (stage_ready),
        .out_ch      (blit_out)
    );

endmodule

@@ test/csb_pixel_checker.sv @@
// Result checker for the clipped sprite blitter: mirrors the clip registers off the APB port,
// predicts one pixel write result per accepted byte and compares results in arrival order.
// Depends on csb_pkg and the channel interfaces in csb_ifs.
module csb_pixel_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    sprite_in_if                           sprite_ch,
    blit_out_if                            blit_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [csb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csb_pkg::APB_DATA_W-1:0] pwdata,
    output int                             mismatches,
    output int                             pending,
    output int                             writes_seen
);
    import csb_pkg::*;

    // clip window as the block holds it
    int clip_l, clip_tp, clip_r, clip_b;

    // sprite walk state
    phase_t      phase;
    logic [15:0] spr_w, spr_h;
    int          org_x, org_y;
    int          col, row;
    logic [31:0] run_off;
    logic        rejected;

    res_t expected_writes[$];

    function automatic int saturate(int v, int hi);
        return v < -1 ? -1 : (v > hi ? hi : v);
    endfunction

    function automatic void load_clip(logic [APB_ADDR_W-1:0] addr,
                                      logic [APB_DATA_W-1:0] data);
        int wide, narrow;
        wide   = $signed(data[9:0]);
        narrow = $signed(data[8:0]);
        case (reg_idx_t'(addr[3:2]))
            REG_CLIP_LEFT:   clip_l  = saturate(wide, SCREEN_WIDTH);
            REG_CLIP_TOP:    clip_tp = saturate(narrow, SCREEN_HEIGHT);
            REG_CLIP_RIGHT:  clip_r  = saturate(wide, SCREEN_WIDTH);
            REG_CLIP_BOTTOM: clip_b  = saturate(narrow, SCREEN_HEIGHT);
            default: ;
        endcase
    endfunction

    // empty window, off screen, or clear of the window
    function automatic logic sprite_rejected();
        int w, h;
        w = int'(spr_w);
        h = int'(spr_h);
        if (clip_l >= clip_r || clip_tp >= clip_b)
            return 1'b1;
        if (org_x <= -w || org_x > SCREEN_WIDTH - 1 ||
            org_y <= -h || org_y > SCREEN_HEIGHT - 1)
            return 1'b1;
        return org_x < clip_l - w || org_x > clip_r ||
               org_y < clip_tp - h || org_y > clip_b;
    endfunction

    function automatic res_t blit_step(logic starts, int x, int y, logic [7:0] data);
        res_t r;
        int   px, py;
        r = '0;
        if (starts)
        begin
            org_x    = x;
            org_y    = y;
            rejected = 1'b1;
            spr_w    = {8'h00, data};
            phase    = PH_W_HI;
        end
        else
        begin
            case (phase)
                PH_W_HI:
                begin
                    spr_w[15:8] = data;
                    phase       = PH_H_LO;
                end
                PH_H_LO:
                begin
                    spr_h = {8'h00, data};
                    phase = PH_H_HI;
                end
                PH_H_HI:
                begin
                    spr_h[15:8] = data;
                    rejected    = sprite_rejected();
                    col         = 0;
                    row         = 0;
                    run_off     = 32'(org_y * LINE_STRIDE + org_x);
                    if (spr_w == 0 || spr_h == 0)
                    begin
                        r.sprite_done = 1'b1;
                        phase         = PH_IDLE;
                    end
                    else
                        phase = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    px = col + org_x;
                    py = row + org_y;
                    if (!rejected && px > clip_l && px < clip_r &&
                        py > clip_tp && py < clip_b)
                    begin
                        r.write_enable = 1'b1;
                        r.write_offset = run_off[15:0];
                        r.pixel_value  = data;
                    end
                    col++;
                    run_off++;
                    if (col >= int'(spr_w))
                    begin
                        // wrap to the next line of the frame buffer
                        col = 0;
                        row++;
                        run_off = run_off + 32'(LINE_STRIDE) - 32'(spr_w);
                        if (row >= int'(spr_h))
                        begin
                            r.sprite_done = 1'b1;
                            phase         = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want, got;
        if (!rst_n)
        begin
            clip_l   = -1;
            clip_tp  = -1;
            clip_r   = SCREEN_WIDTH;
            clip_b   = SCREEN_HEIGHT;
            phase    = PH_IDLE;
            spr_w    = '0;
            spr_h    = '0;
            org_x    = 0;
            org_y    = 0;
            col      = 0;
            row      = 0;
            run_off  = '0;
            rejected = 1'b1;
            expected_writes.delete();
            mismatches  = 0;
            writes_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                load_clip(paddr, pwdata);
            if (sprite_ch.valid && sprite_ch.ready)
                expected_writes.push_back(blit_step(sprite_ch.first, sprite_ch.pos_x,
                                                    sprite_ch.pos_y, sprite_ch.sprite_byte));
            if (blit_ch.valid && blit_ch.ready)
            begin
                got.write_enable = blit_ch.write_enable;
                got.write_offset = blit_ch.write_offset;
                got.pixel_value  = blit_ch.pixel_value;
                got.sprite_done  = blit_ch.sprite_done;
                if (got.write_enable)
                    writes_seen++;
                if (expected_writes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no item outstanding: we=%b off=%0d pix=%0d done=%b",
                                 $realtime, got.write_enable, got.write_offset,
                                 got.pixel_value, got.sprite_done);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (want.write_enable !== got.write_enable ||
                        want.write_offset !== got.write_offset ||
                        want.pixel_value  !== got.pixel_value ||
                        want.sprite_done  !== got.sprite_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected we=%b off=%0d pix=%0d done=%b, got we=%b off=%0d pix=%0d done=%b",
                                     $realtime, want.write_enable, want.write_offset,
                                     want.pixel_value, want.sprite_done, got.write_enable,
                                     got.write_offset, got.pixel_value, got.sprite_done);
                    end
                end
            end
        end
        pending = expected_writes.size();
    end

endmodule

@@ test/clipped_sprite_blit_test.sv @@
// Top of the clipped sprite blitter test: clock, reset, sprite byte stimulus, clip window
// programming over APB and output back-pressure; verdict comes from csb_pixel_checker.
// Depends on csb_pkg, csb_ifs, clipped_sprite_blit and csb_pixel_checker.
module clipped_sprite_blit_test;
    import csb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1050;
    localparam int QUIET_AFTER = 900;
    localparam int CFG_SPACING = 110;

    logic                  clk;
    logic                  rst_n;
    logic                  psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;

    int mismatches, pending, writes_seen;
    int cycles = 0;
    int bytes_sent = 0, noise_sent = 0;
    int sprites_sent = 0, sprites_cut = 0, windows_set = 0;
    int next_window_at = 0;
    int stall_left = 0;
    bit gap_on = 0, stall_on = 0, quiet = 0;

    sprite_in_if sprite_ch();
    blit_out_if  blit_ch();

    clipped_sprite_blit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sprite_in (sprite_ch),
        .blit_out  (blit_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    csb_pixel_checker pixel_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .sprite_ch   (sprite_ch),
        .blit_ch     (blit_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .writes_seen (writes_seen)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output back-pressure in short bursts
    initial
    begin
        blit_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && stall_on && !quiet && $urandom_range(0, 6) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                blit_ch.ready = 1'b0;
                stall_left--;
            end
            else
                blit_ch.ready = 1'b1;
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // drain the block, then program a new clip window
    task automatic set_window();
        int kind, l, t, r, b;
        sprite_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        kind = windows_set < 5 ? windows_set : $urandom_range(0, 4);
        l = -1;
        t = -1;
        r = SCREEN_WIDTH;
        b = SCREEN_HEIGHT;
        case (kind)
            1:
            begin
                l = $urandom_range(0, 250);
                l = l - 1;
                r = l + $urandom_range(1, 80);
                t = $urandom_range(0, 150);
                t = t - 1;
                b = t + $urandom_range(1, 60);
            end
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // inverted extremes
                    l = SCREEN_WIDTH;
                    r = -1;
                    t = SCREEN_HEIGHT;
                    b = -1;
                end
                else
                begin
                    l = $urandom_range(0, 319);
                    r = l - $urandom_range(0, 2);
                    t = $urandom_range(0, 199);
                    b = t + $urandom_range(1, 40);
                end
            end
            3:
            begin
                // raw bus values, saturated by the block
                l = $urandom;
                t = $urandom;
                r = $urandom;
                b = $urandom;
            end
            4:
            begin
                // a single visible column and row
                l = $urandom_range(0, 319);
                l = l - 1;
                r = l + 2;
                t = $urandom_range(0, 199);
                t = t - 1;
                b = t + 2;
            end
            default: ;
        endcase
        apb_write(REG_CLIP_LEFT, 32'(l));
        apb_write(REG_CLIP_TOP, 32'(t));
        apb_write(REG_CLIP_RIGHT, 32'(r));
        apb_write(REG_CLIP_BOTTOM, 32'(b));
        windows_set++;
    endtask

    task automatic send_byte(logic is_first, logic [15:0] px, logic [15:0] py,
                             logic [7:0] data);
        if (next_window_at > 0 && bytes_sent >= next_window_at)
        begin
            set_window();
            next_window_at += CFG_SPACING;
        end
        if (gap_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            sprite_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5))
                @(negedge clk);
        end
        sprite_ch.valid       = 1'b1;
        sprite_ch.first       = is_first;
        sprite_ch.pos_x       = px;
        sprite_ch.pos_y       = py;
        sprite_ch.sprite_byte = data;
        do
            @(posedge clk);
        while (!sprite_ch.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_noise(logic [7:0] data);
        noise_sent++;
        send_byte(1'b0, 16'($urandom), 16'($urandom), data);
    endtask

    // header then pixels; stop after cut pixels when cut is not negative and below w*h
    task automatic send_sprite(int x, int y, int w, int h, int cut);
        longint total;
        sprites_sent++;
        send_byte(1'b1, 16'(x), 16'(y), w[7:0]);
        send_byte(1'b0, 16'($urandom), 16'($urandom), w[15:8]);
        send_byte(1'b0, 16'($urandom), 16'($urandom), h[7:0]);
        send_byte(1'b0, 16'($urandom), 16'($urandom), h[15:8]);
        total = longint'(w) * longint'(h);
        if (cut >= 0 && cut < total)
        begin
            total = cut;
            sprites_cut++;
        end
        repeat (total)
            send_byte(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int x, y, pick;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        sprite_ch.valid       = 1'b0;
        sprite_ch.first       = 1'b0;
        sprite_ch.pos_x       = '0;
        sprite_ch.pos_y       = '0;
        sprite_ch.sprite_byte = '0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: stray bytes, corners, empty sprites, extreme positions, abandon
        gap_on   = 1'b1;
        stall_on = 1'b1;
        send_noise(8'h00);
        send_noise(8'hFF);
        send_sprite(0, 0, 2, 2, -1);
        send_sprite(5, 5, 0, 7, -1);
        send_sprite(319, 199, 2, 1, -1);
        send_sprite(-32768, 32767, 1, 1, -1);
        send_sprite(-1, -1, 65535, 65535, 1);
        send_sprite(32767, -32768, 3, 0, -1);

        next_window_at = bytes_sent + CFG_SPACING / 2;
        while (bytes_sent - noise_sent < ITEM_TARGET)
        begin
            quiet    = (bytes_sent - noise_sent) > QUIET_AFTER;
            gap_on   = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            pick     = $urandom_range(0, 19);
            x = $urandom_range(0, 370);
            x = x - 30;
            y = $urandom_range(0, 240);
            y = y - 20;
            if (pick == 0)
            begin
                x = $urandom_range(0, 65535);
                x = x - 32768;
                y = $urandom_range(0, 65535);
                y = y - 32768;
            end
            if (sprites_sent == 12)
                send_sprite(-5, y, 330, 1, -1);
            else if (pick < 15)
                send_sprite(x, y, $urandom_range(0, 20), $urandom_range(0, 8), -1);
            else if (pick < 18)
                send_sprite(x, y, $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 6));
            else
                repeat ($urandom_range(1, 3))
                    send_noise(8'($urandom));
        end

        sprite_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        $display("Covered %0d sprites (%0d cut short), %0d byte items, %0d clip windows.",
                 sprites_sent, sprites_cut, bytes_sent, windows_set);
        $display("Results carried %0d pixel writes.", writes_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
